@@ rtl/ascm_pkg.sv @@
// Shared types, widths and constants of the axial symmetry class mapper.
package ascm_pkg;

  // Fixed field widths
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned CNT_CFG_W  = 7;
  localparam int unsigned SPACING_W  = 16;
  localparam int unsigned MAG_W      = 7;
  localparam int unsigned PROD_W     = SPACING_W + MAG_W;
  localparam int unsigned SQR_W      = 2 * PROD_W;
  localparam int unsigned CITY_W     = 24;
  localparam int unsigned RAD_W      = 45;
  localparam int unsigned PLANE_W    = 12;
  localparam int unsigned VOL_W      = 18;
  localparam int unsigned CLASS_W    = 11;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned MAX_CLASSES = 2048;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Stream payload widths
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned S_TUSER_W  = 1;
  localparam int unsigned M_TDATA_W  = 56;
  localparam int unsigned M_TUSER_W  = 2;

  // Output tdata bit positions
  localparam int unsigned M_CLASS_LSB = 0;
  localparam int unsigned M_PLANE_LSB = M_CLASS_LSB + CLASS_W;
  localparam int unsigned M_VOL_LSB   = M_PLANE_LSB + PLANE_W;
  localparam int unsigned M_COUNT_LSB = M_VOL_LSB + VOL_W;
  localparam int unsigned M_USED_W    = M_COUNT_LSB + COUNT_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X    = 3'd0,
    CFG_GRID_Y    = 3'd1,
    CFG_GRID_Z    = 3'd2,
    CFG_SPACING_X = 3'd3,
    CFG_SPACING_Y = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] grid_x_count;
    logic [CNT_CFG_W-1:0] grid_y_count;
    logic [CNT_CFG_W-1:0] grid_z_count;
    logic [SPACING_W-1:0] spacing_x;
    logic [SPACING_W-1:0] spacing_y;
  } cfg_t;

  // One stored class
  typedef struct packed {
    logic [CITY_W-1:0]  city;
    logic [RAD_W-1:0]   rad;
    logic [PLANE_W-1:0] plane;
  } class_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY_MUL,
    ST_KEY_SQR,
    ST_KEY_SUM,
    ST_SCAN,
    ST_RESOLVE,
    ST_VOL,
    ST_EMIT
  } fsm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic key_mul;
    logic key_sqr;
    logic scan_init;
    logic scan;
    logic resolve;
    logic vol;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/ascm_ctrl.sv @@
// Sequencing state machine of the axial symmetry class mapper.
module ascm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  ascm_pkg::dp_status_t sts_i,
  output ascm_pkg::ctrl_cmd_t  cmd_o
);
  import ascm_pkg::*;

  fsm_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_KEY_MUL;
        end
      end
      ST_KEY_MUL: begin
        cmd_o.key_mul = 1'b1;
        state_d       = ST_KEY_SQR;
      end
      ST_KEY_SQR: begin
        cmd_o.key_sqr = 1'b1;
        state_d       = ST_KEY_SUM;
      end
      ST_KEY_SUM: begin
        cmd_o.scan_init = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_VOL;
      end
      ST_VOL: begin
        cmd_o.vol = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ascm_datapath.sv @@
// Key arithmetic, class table with sequential scan, and output register.
module ascm_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ascm_pkg::cfg_t                    cfg_i,
  input  ascm_pkg::ctrl_cmd_t               cmd_i,
  output ascm_pkg::dp_status_t              sts_o,
  input  logic [ascm_pkg::IDX_W-1:0]        x_index_i,
  input  logic [ascm_pkg::IDX_W-1:0]        y_index_i,
  input  logic [ascm_pkg::IDX_W-1:0]        z_index_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ascm_pkg::CLASS_W-1:0]      class_number_o,
  output logic [ascm_pkg::PLANE_W-1:0]      rep_plane_index_o,
  output logic [ascm_pkg::VOL_W-1:0]        rep_volume_index_o,
  output logic                              is_new_o,
  output logic                              overflow_o,
  output logic [ascm_pkg::COUNT_W-1:0]      class_count_o
);
  import ascm_pkg::*;

  // Point registers
  logic [IDX_W-1:0]   x_q, y_q, z_q;
  logic [COUNT_W-1:0] count_q;

  // Key pipeline
  logic [MAG_W-1:0]   twice_x, twice_y, mag_a, mag_b;
  logic [PROD_W-1:0]  pa_q, pb_q;
  logic [SQR_W-1:0]   sqa_q, sqb_q;
  logic [CITY_W-1:0]  city_q;
  logic [RAD_W-1:0]   rad_q;
  logic [PLANE_W-1:0] plane_new_q;
  logic [12:0]        plane_prod;

  // Scan
  class_entry_t       mem [MAX_CLASSES];
  class_entry_t       rd_q;
  logic [COUNT_W-1:0] iss_q;
  logic [CLASS_W-1:0] rd_idx_q;
  logic               cmp_vld_q;
  logic               hit_q;
  logic [CLASS_W-1:0] found_q;
  logic [PLANE_W-1:0] found_plane_q;
  logic               match, issue;

  // Resolution
  logic [CLASS_W-1:0] cls_q;
  logic [PLANE_W-1:0] plane_q;
  logic               is_new_q, ovf_q;
  logic [VOL_W-1:0]   vol_q;
  logic [18:0]        vol_full;

  // Output register
  logic               out_vld_q;

  // Doubled centred offsets, magnitude only
  always_comb begin
    twice_x = {x_q, 1'b0};
    twice_y = {y_q, 1'b0};
    mag_a   = (twice_x >= cfg_i.grid_x_count) ? twice_x - cfg_i.grid_x_count
                                              : cfg_i.grid_x_count - twice_x;
    mag_b   = (twice_y >= cfg_i.grid_y_count) ? twice_y - cfg_i.grid_y_count
                                              : cfg_i.grid_y_count - twice_y;
    plane_prod = 13'(x_q) * 13'(cfg_i.grid_y_count) + 13'(y_q);
    vol_full   = 19'(plane_q) * 19'(cfg_i.grid_z_count) + 19'(z_q);
  end

  // Capture the point; restart empties the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load && restart_i) begin
      count_q <= '0;
    end else if (cmd_i.resolve && !hit_q && (count_q < COUNT_W'(MAX_CLASSES))) begin
      count_q <= count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_index_i;
      y_q <= y_index_i;
      z_q <= z_index_i;
    end
  end

  // Key arithmetic, one multiplier level per stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.key_mul) begin
      pa_q        <= PROD_W'(cfg_i.spacing_x) * PROD_W'(mag_a);
      pb_q        <= PROD_W'(cfg_i.spacing_y) * PROD_W'(mag_b);
      plane_new_q <= plane_prod[PLANE_W-1:0];
    end
    if (cmd_i.key_sqr) begin
      city_q <= CITY_W'(pa_q) + CITY_W'(pb_q);
      sqa_q  <= SQR_W'(pa_q) * SQR_W'(pa_q);
      sqb_q  <= SQR_W'(pb_q) * SQR_W'(pb_q);
    end
    if (cmd_i.scan_init) begin
      rad_q <= RAD_W'(sqa_q + sqb_q);
    end
  end

  // Scan: issue one read a cycle, compare the registered entry
  assign match = cmp_vld_q && (rd_q.city == city_q) && (rd_q.rad == rad_q);
  assign issue = cmd_i.scan && !hit_q && !match && (iss_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd_i.scan_init) begin
      iss_q     <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd_i.scan) begin
      cmp_vld_q <= issue;
      if (issue) begin
        iss_q <= iss_q + COUNT_W'(1);
      end
      if (match) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= iss_q[CLASS_W-1:0];
    end
    if (match && !hit_q) begin
      found_q       <= rd_idx_q;
      found_plane_q <= rd_q.plane;
    end
  end

  // Class table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem[iss_q[CLASS_W-1:0]];
    end
    if (cmd_i.resolve && !hit_q && (count_q < COUNT_W'(MAX_CLASSES))) begin
      mem[count_q[CLASS_W-1:0]] <= '{city: city_q, rad: rad_q, plane: plane_new_q};
    end
  end

  assign sts_o.scan_done = hit_q || (!cmp_vld_q && (iss_q >= count_q));

  // Resolve hit, append or overflow
  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      if (hit_q) begin
        cls_q    <= found_q;
        plane_q  <= found_plane_q;
        is_new_q <= 1'b0;
        ovf_q    <= 1'b0;
      end else if (count_q < COUNT_W'(MAX_CLASSES)) begin
        cls_q    <= count_q[CLASS_W-1:0];
        plane_q  <= plane_new_q;
        is_new_q <= 1'b1;
        ovf_q    <= 1'b0;
      end else begin
        cls_q    <= '0;
        plane_q  <= '0;
        is_new_q <= 1'b0;
        ovf_q    <= 1'b1;
      end
    end
    if (cmd_i.vol) begin
      vol_q <= ovf_q ? '0 : vol_full[VOL_W-1:0];
    end
  end

  // Output register, freed by a downstream transaction
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      class_number_o     <= cls_q;
      rep_plane_index_o  <= plane_q;
      rep_volume_index_o <= vol_q;
      is_new_o           <= is_new_q;
      overflow_o         <= ovf_q;
      class_count_o      <= count_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/axial_symmetry_class_mapper.sv @@
// A point is loaded in idle, then passes key multiply, key square, key sum, scan,
// resolve, volume and emit. The scan covers every stored class (at most 2048) on a
// miss and stops at the matching entry on a hit; it reads one table entry per cycle.
// Points are taken only in idle; a result awaiting transfer holds the next one in emit.
// Reset clears the class count, the controller and the output valid; table entries
// are not cleared, only entries below the count are ever read.
module axial_symmetry_class_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ascm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ascm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [ascm_pkg::S_TDATA_W-1:0]      s_tdata_i,  // x_index, y_index, z_index
  input  logic [ascm_pkg::S_TUSER_W-1:0]      s_tuser_i,  // restart
  // Output stream
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [ascm_pkg::M_TDATA_W-1:0]      m_tdata_o,  // class_number, rep_plane_index,
                                                          // rep_volume_index, class_count
  output logic [ascm_pkg::M_TUSER_W-1:0]      m_tuser_o   // is_new, overflow
);
  import ascm_pkg::*;

  cfg_t       cfg_q;
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  logic [CLASS_W-1:0] class_number;
  logic [PLANE_W-1:0] rep_plane_index;
  logic [VOL_W-1:0]   rep_volume_index;
  logic               is_new, overflow;
  logic [COUNT_W-1:0] class_count;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_x_count <= CNT_CFG_W'(64);
      cfg_q.grid_y_count <= CNT_CFG_W'(64);
      cfg_q.grid_z_count <= CNT_CFG_W'(64);
      cfg_q.spacing_x    <= SPACING_W'(256);
      cfg_q.spacing_y    <= SPACING_W'(256);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_X:    cfg_q.grid_x_count <= cfg_data_i[CNT_CFG_W-1:0];
        CFG_GRID_Y:    cfg_q.grid_y_count <= cfg_data_i[CNT_CFG_W-1:0];
        CFG_GRID_Z:    cfg_q.grid_z_count <= cfg_data_i[CNT_CFG_W-1:0];
        CFG_SPACING_X: cfg_q.spacing_x    <= cfg_data_i;
        CFG_SPACING_Y: cfg_q.spacing_y    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ascm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ascm_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .x_index_i          (s_tdata_i[IDX_W-1:0]),
    .y_index_i          (s_tdata_i[2*IDX_W-1:IDX_W]),
    .z_index_i          (s_tdata_i[3*IDX_W-1:2*IDX_W]),
    .restart_i          (s_tuser_i[0]),
    .out_valid_o        (m_tvalid_o),
    .out_ready_i        (m_tready_i),
    .class_number_o     (class_number),
    .rep_plane_index_o  (rep_plane_index),
    .rep_volume_index_o (rep_volume_index),
    .is_new_o           (is_new),
    .overflow_o         (overflow),
    .class_count_o      (class_count)
  );

  // Pack the result
  assign m_tdata_o = {(M_TDATA_W - M_USED_W)'(0), class_count, rep_volume_index,
                      rep_plane_index, class_number};
  assign m_tuser_o = {overflow, is_new};

endmodule

@@ rtl/ascm_checker.sv @@
// Port-level assertions of the axial symmetry class mapper, bound to the top level.
module ascm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                m_tvalid_o,
  input logic                                m_tready_i,
  input logic [ascm_pkg::M_TDATA_W-1:0]      m_tdata_o,
  input logic [ascm_pkg::M_TUSER_W-1:0]      m_tuser_o
);
  import ascm_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled result dropped or changed");

  // A new class and an overflow never come together
  a_new_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(m_tuser_o[0] && m_tuser_o[1]))
    else $error("new class flagged on overflow");

  // A new class is the last one stored
  a_new_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[0] |->
      m_tdata_o[M_COUNT_LSB +: COUNT_W] ==
        ({1'b0, m_tdata_o[M_CLASS_LSB +: CLASS_W]} + COUNT_W'(1)))
    else $error("new class number does not match class count");

  // Overflow only on a full table, with a zeroed class number
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] |->
      (m_tdata_o[M_COUNT_LSB +: COUNT_W] == COUNT_W'(MAX_CLASSES)) &&
      (m_tdata_o[M_CLASS_LSB +: CLASS_W] == '0))
    else $error("overflow without a full table");

endmodule

bind axial_symmetry_class_mapper ascm_checker u_ascm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o)
);

@@ verif/axial_symmetry_class_mapper_tb.sv @@
// Self-checking testbench for the axial symmetry class mapper: streamed points against a class table predictor.
`timescale 1ns / 100ps

module axial_symmetry_class_mapper_tb;
  import ascm_pkg::*;

  localparam int unsigned      CLK_HALF_NS   = 6;
  localparam int unsigned      RESET_CYCLES  = 11;
  localparam int unsigned      SETTLE_CYCLES = 64;
  localparam longint unsigned  TIMEOUT_NS    = 200_000_000;
  // Register indexes past the end of the register list; writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = 3'd7;

  typedef struct {
    logic [CLASS_W-1:0] class_number;
    logic [PLANE_W-1:0] rep_plane;
    logic [VOL_W-1:0]   rep_volume;
    logic               is_new;
    logic               overflow;
    logic [COUNT_W-1:0] class_count;
  } class_result_t;

  // Tracks the class table and register state, predicts each class result
  class symmetry_class_tracker;
    logic [CNT_CFG_W-1:0] nx, ny, nz;
    logic [SPACING_W-1:0] dx, dy;
    logic [CITY_W-1:0]    city_keys  [MAX_CLASSES];
    logic [RAD_W-1:0]     rad_keys   [MAX_CLASSES];
    logic [PLANE_W-1:0]   plane_reps [MAX_CLASSES];
    int unsigned          stored;
    class_result_t        pending_results[$];
    int unsigned          mismatches;
    int unsigned          results_seen;

    function new();
      nx = 7'd64;
      ny = 7'd64;
      nz = 7'd64;
      dx = 16'd256;
      dy = 16'd256;
      stored = 0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_X:    nx = data[CNT_CFG_W-1:0];
        CFG_GRID_Y:    ny = data[CNT_CFG_W-1:0];
        CFG_GRID_Z:    nz = data[CNT_CFG_W-1:0];
        CFG_SPACING_X: dx = data;
        CFG_SPACING_Y: dy = data;
        default: ;
      endcase
    endfunction

    // Magnitude of the doubled, centred offset |2*idx - cnt|
    function longint unsigned doubled_offset(logic [IDX_W-1:0] idx, logic [CNT_CFG_W-1:0] cnt);
      longint unsigned twice;
      longint unsigned count;
      twice = idx;
      twice = twice * 2;
      count = cnt;
      return (twice >= count) ? (twice - count) : (count - twice);
    endfunction

    // Look up or open the class of one accepted point and queue its result
    function void note_point(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y, logic [IDX_W-1:0] z,
                             logic restart);
      longint unsigned prod_a, prod_b, wide_plane;
      logic [CITY_W-1:0] city;
      logic [RAD_W-1:0]  rad;
      class_result_t     res;
      int                hit_at;
      if (restart) stored = 0;
      prod_a = doubled_offset(x, nx) * longint'(dx);
      prod_b = doubled_offset(y, ny) * longint'(dy);
      city = CITY_W'(prod_a + prod_b);
      rad  = RAD_W'(prod_a * prod_a + prod_b * prod_b);
      hit_at = -1;
      for (int i = 0; i < int'(stored); i++) begin
        if (city_keys[i] == city && rad_keys[i] == rad) begin
          hit_at = i;
          break;
        end
      end
      res = '{default: '0};
      if (hit_at >= 0) begin
        res.class_number = CLASS_W'(hit_at);
        res.rep_plane    = plane_reps[hit_at];
      end else if (stored < MAX_CLASSES) begin
        wide_plane = longint'(x) * longint'(ny) + longint'(y);
        city_keys[stored]  = city;
        rad_keys[stored]   = rad;
        plane_reps[stored] = PLANE_W'(wide_plane);
        res.class_number   = CLASS_W'(stored);
        res.rep_plane      = plane_reps[stored];
        res.is_new         = 1'b1;
        stored++;
      end else begin
        res.overflow = 1'b1;
      end
      if (!res.overflow) begin
        wide_plane = res.rep_plane;
        res.rep_volume = VOL_W'(wide_plane * longint'(nz) + longint'(z));
      end
      res.class_count = COUNT_W'(stored);
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Compare one accepted result against the oldest prediction
    task check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
      class_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result data %h user %b", data, user));
        return;
      end
      want = pending_results.pop_front();
      compare_field("class_number", 32'(data[M_CLASS_LSB +: CLASS_W]), 32'(want.class_number));
      compare_field("rep_plane_index", 32'(data[M_PLANE_LSB +: PLANE_W]), 32'(want.rep_plane));
      compare_field("rep_volume_index", 32'(data[M_VOL_LSB +: VOL_W]), 32'(want.rep_volume));
      compare_field("class_count", 32'(data[M_COUNT_LSB +: COUNT_W]), 32'(want.class_count));
      compare_field("is_new", 32'(user[0]), 32'(want.is_new));
      compare_field("overflow", 32'(user[1]), 32'(want.overflow));
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  s_tvalid_i  = 1'b0;
  logic                  s_tready_o;
  logic [S_TDATA_W-1:0]  s_tdata_i   = '0;
  logic [S_TUSER_W-1:0]  s_tuser_i   = '0;
  logic                  m_tvalid_o;
  logic                  m_tready_i  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata_o;
  logic [M_TUSER_W-1:0]  m_tuser_o;

  symmetry_class_tracker tracker;
  int unsigned           tx_idle_pct = 0;
  int unsigned           rx_idle_pct = 0;

  axial_symmetry_class_mapper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  initial begin
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Check each result transaction, then pick the next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) tracker.check_result(m_tdata_o, m_tuser_o);
    if (rst_ni) m_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Offer one point, optionally after an idle gap, and hold it until accepted
  task automatic send_point(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y, logic [IDX_W-1:0] z,
                            logic restart);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= S_TDATA_W'({z, y, x});
    s_tuser_i  <= restart;
    do @(posedge clk_i); while (!s_tready_o);
    tracker.note_point(x, y, z, restart);
  endtask

  // Drop valid and wait for every predicted result to come back
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd64;
      3:       return 16'd127;
      4:       return CFG_DATA_W'($urandom_range(16'hFFFF));
      5, 6:    return CFG_DATA_W'($urandom_range(1, 16));
      default: return CFG_DATA_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_spacing();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd256;
      3, 4:    return CFG_DATA_W'($urandom_range(16'hFFFF));
      default: return CFG_DATA_W'($urandom_range(1, 1023));
    endcase
  endfunction

  // Mostly a lattice index inside the grid in use, sometimes anywhere
  function automatic logic [IDX_W-1:0] pick_index(logic [CNT_CFG_W-1:0] cnt);
    if (cnt != 0 && cnt <= 64 && $urandom_range(9) != 0)
      return IDX_W'($urandom_range(cnt - 1));
    return IDX_W'($urandom_range(63));
  endfunction

  // Groups of random points, each under a freshly drawn register setting
  task automatic run_random_phase(int unsigned n_items);
    int unsigned      sent;
    int unsigned      group;
    logic [IDX_W-1:0] x, y, z, px, py;
    logic             restart;
    sent = 0;
    px = '0;
    py = '0;
    while (sent < n_items) begin
      wait_idle();
      if ($urandom_range(1)) write_register(CFG_GRID_X, pick_count());
      if ($urandom_range(1)) write_register(CFG_GRID_Y, pick_count());
      if ($urandom_range(1)) write_register(CFG_GRID_Z, pick_count());
      if ($urandom_range(1)) write_register(CFG_SPACING_X, pick_spacing());
      if ($urandom_range(1)) write_register(CFG_SPACING_Y, pick_spacing());
      if ($urandom_range(7) == 0)
        write_register(CFG_IDX_W'($urandom_range(CFG_PAST_LAST, CFG_TOP_INDEX)),
                       CFG_DATA_W'($urandom_range(16'hFFFF)));
      group = $urandom_range(10, 30);
      for (int k = 0; k < int'(group) && sent < n_items; k++) begin
        // Mirror the previous point now and then to hit existing classes
        if ($urandom_range(2) == 0) begin
          x = IDX_W'(tracker.nx - px);
          y = IDX_W'(tracker.ny - py);
        end else begin
          x = pick_index(tracker.nx);
          y = pick_index(tracker.ny);
        end
        if ($urandom_range(4) == 0) {x, y} = {y, x};
        z = pick_index(tracker.nz);
        restart = (k == 0 && $urandom_range(1) == 0) || $urandom_range(29) == 0;
        send_point(x, y, z, restart);
        px = x;
        py = y;
        sent++;
      end
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("axial_symmetry_class_mapper_tb: errors");
    $finish;
  end

  initial begin
    tracker = new();
    tx_idle_pct = 15;
    rx_idle_pct = 48;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: repeats, mirrored points, the centre and restarts
    send_point(6'd0, 6'd0, 6'd0, 1'b1);
    send_point(6'd0, 6'd0, 6'd0, 1'b0);
    send_point(6'd63, 6'd63, 6'd63, 1'b0);
    send_point(6'd1, 6'd1, 6'd5, 1'b0);
    send_point(6'd32, 6'd32, 6'd17, 1'b0);
    send_point(6'd1, 6'd0, 6'd9, 1'b0);
    send_point(6'd0, 6'd1, 6'd40, 1'b0);
    send_point(6'd63, 6'd0, 6'd2, 1'b0);
    send_point(6'd0, 6'd63, 6'd63, 1'b1);

    // Zero and oversized counts, extreme spacings, dropped out-of-list writes
    wait_idle();
    write_register(CFG_GRID_X, 16'hFF80);
    write_register(CFG_GRID_Y, 16'h007F);
    write_register(CFG_GRID_Z, 16'h0000);
    write_register(CFG_SPACING_X, 16'hFFFF);
    write_register(CFG_SPACING_Y, 16'h0000);
    write_register(CFG_PAST_LAST, 16'hFFFF);
    write_register(CFG_TOP_INDEX, 16'h1234);
    send_point(6'd63, 6'd63, 6'd63, 1'b0);
    send_point(6'd0, 6'd0, 6'd0, 1'b0);
    send_point(6'd63, 6'd0, 6'd63, 1'b0);
    send_point(6'd0, 6'd63, 6'd1, 1'b0);

    wait_idle();
    write_register(CFG_GRID_X, 16'd127);
    write_register(CFG_GRID_Z, 16'd127);
    write_register(CFG_SPACING_Y, 16'hFFFF);
    send_point(6'd0, 6'd0, 6'd63, 1'b0);
    send_point(6'd63, 6'd63, 6'd63, 1'b0);
    send_point(6'd63, 6'd0, 6'd0, 1'b0);
    send_point(6'd0, 6'd63, 6'd31, 1'b1);

    run_random_phase(190);
    tx_idle_pct = 48;
    rx_idle_pct = 15;
    run_random_phase(190);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random_phase(200);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("axial_symmetry_class_mapper_tb: clean");
    end else begin
      $display("axial_symmetry_class_mapper_tb: errors");
    end
    $finish;
  end

endmodule
